// ----- sv/mrq_pkg.sv -----
// ============================================================================
// mrq_pkg: shared types and constants for the message ring queue
// Widths, request and status codes, and the storage command bundle.
// ============================================================================
package mrq_pkg;

    localparam int DEPTH     = 64;
    localparam int MSG_W     = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;

    // request codes
    localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_W-1:0] OP_GET    = 2'd1;
    localparam logic [OP_W-1:0] OP_BROWSE = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QSIZE     = 1'd1;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [MSG_W-1:0] wr_data;
        logic             wr_valid;
        logic             clr_all;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } t_store_cmd;

endpackage

// ----- sv/mrq_req_if.sv -----
// ============================================================================
// mrq_req_if: request channel
// valid/ready handshake carrying one put, get or browse request word.
// ============================================================================
interface mrq_req_if;
    logic                       valid;
    logic                       ready;
    logic [mrq_pkg::OP_W-1:0]   op;
    logic [mrq_pkg::MSG_W-1:0]  msg_in;
    logic                       browse_start;
    logic [mrq_pkg::IDX_W-1:0]  browse_location;

    modport source (
        output valid, op, msg_in, browse_start, browse_location,
        input  ready
    );
    modport sink (
        input  valid, op, msg_in, browse_start, browse_location,
        output ready
    );
endinterface

// ----- sv/mrq_rsp_if.sv -----
// ============================================================================
// mrq_rsp_if: response channel
// valid/ready handshake carrying one result word per request.
// ============================================================================
interface mrq_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [mrq_pkg::STATUS_W-1:0] status;
    logic [mrq_pkg::MSG_W-1:0]    msg_out;
    logic [mrq_pkg::IDX_W-1:0]    next_location;
    logic [mrq_pkg::CNT_W-1:0]    fill_count;
    logic [mrq_pkg::CNT_W-1:0]    high_water;

    modport source (
        output valid, status, msg_out, next_location, fill_count, high_water,
        input  ready
    );
    modport sink (
        input  valid, status, msg_out, next_location, fill_count, high_water,
        output ready
    );
endinterface

// ----- sv/mrq_ring_alu.sv -----
// ============================================================================
// mrq_ring_alu: ring index adder
// (a + b) mod size with one add and one compare-subtract; a < size, b <= size.
// ============================================================================
module mrq_ring_alu (
    input  logic [mrq_pkg::IDX_W-1:0] i_a,
    input  logic [mrq_pkg::CNT_W-1:0] i_b,
    input  logic [mrq_pkg::CNT_W-1:0] i_size,
    output logic [mrq_pkg::IDX_W-1:0] o_sum
);
    logic [mrq_pkg::CNT_W:0] w_sum;
    logic [mrq_pkg::CNT_W:0] w_wrap;

    always_comb begin
        w_sum  = {{(mrq_pkg::CNT_W + 1 - mrq_pkg::IDX_W){1'b0}}, i_a} + {1'b0, i_b};
        w_wrap = w_sum - {1'b0, i_size};
        if (w_sum >= {1'b0, i_size}) begin
            o_sum = w_wrap[mrq_pkg::IDX_W-1:0];
        end else begin
            o_sum = w_sum[mrq_pkg::IDX_W-1:0];
        end
    end
endmodule

// ----- sv/mrq_store.sv -----
// ============================================================================
// mrq_store: slot storage
// Handle memory with one write and one registered read port, plus per-slot
// valid flags that reset and a queue resize clear at once.
// ============================================================================
module mrq_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mrq_pkg::t_store_cmd         i_cmd,
    output logic [mrq_pkg::DEPTH-1:0]   o_valid,
    output logic [mrq_pkg::MSG_W-1:0]   o_rd_data
);
    logic [mrq_pkg::MSG_W-1:0] r_mem [mrq_pkg::DEPTH];
    logic [mrq_pkg::MSG_W-1:0] r_rd_data;
    logic [mrq_pkg::DEPTH-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_all) begin
            r_valid <= '0;
        end else if (i_cmd.wr_en) begin
            r_valid[i_cmd.wr_addr] <= i_cmd.wr_valid;
        end
    end

    assign o_valid   = r_valid;
    assign o_rd_data = r_rd_data;
endmodule

// ----- sv/message_ring_queue.sv -----
// Put and get: the request word is taken in S_IDLE and passes S_EXEC, then S_PUT or
// S_GET, then S_FINISH, where the result is registered (a rejected put or an empty
// get skips S_PUT and S_GET). Browse: the cursor walks one slot per cycle through
// the shared ring adder, two passes at most. A new request is taken only in S_IDLE.
// Synchronous active-low reset: queue empty, overwrite on, queue_size 64.
// Writing queue_size also empties the queue and clears the high-water mark.
// ============================================================================
// message_ring_queue: ring queue of message handles
// Sequencer over a shared ring index adder and the slot store; handles put,
// get and browse requests and tracks fill count and high-water mark.
// ============================================================================
module message_ring_queue (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mrq_req_if.sink                         i_req,
    mrq_rsp_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [mrq_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mrq_pkg::CFG_W-1:0]       i_cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_PUT,
        S_GET,
        S_SCAN1,
        S_CHK,
        S_SCAN2,
        S_BR_RD,
        S_FINISH
    } t_state;

    t_state r_state, n_state;

    logic [mrq_pkg::OP_W-1:0]     r_op, n_op;
    logic [mrq_pkg::MSG_W-1:0]    r_msg_in, n_msg_in;
    logic                         r_start, n_start;
    logic [mrq_pkg::IDX_W-1:0]    r_cursor, n_cursor;
    logic [mrq_pkg::IDX_W-1:0]    r_head, n_head;
    logic [mrq_pkg::CNT_W-1:0]    r_count, n_count;
    logic [mrq_pkg::CNT_W-1:0]    r_peak, n_peak;
    logic                         r_ow, n_ow;
    logic [mrq_pkg::CNT_W-1:0]    r_size, n_size;
    logic [mrq_pkg::IDX_W-1:0]    r_tail, n_tail;
    logic [mrq_pkg::IDX_W-1:0]    r_loc, n_loc;
    logic [mrq_pkg::CNT_W-1:0]    r_iter, n_iter;
    logic [mrq_pkg::STATUS_W-1:0] r_status, n_status;
    logic [mrq_pkg::MSG_W-1:0]    r_msg_out, n_msg_out;
    logic [mrq_pkg::IDX_W-1:0]    r_next, n_next;

    logic                         r_o_valid, n_o_valid;
    logic [mrq_pkg::STATUS_W-1:0] r_o_status, n_o_status;
    logic [mrq_pkg::MSG_W-1:0]    r_o_msg, n_o_msg;
    logic [mrq_pkg::IDX_W-1:0]    r_o_next, n_o_next;
    logic [mrq_pkg::CNT_W-1:0]    r_o_fill, n_o_fill;
    logic [mrq_pkg::CNT_W-1:0]    r_o_high, n_o_high;

    mrq_pkg::t_store_cmd          w_cmd;
    logic [mrq_pkg::DEPTH-1:0]    w_valid;
    logic [mrq_pkg::MSG_W-1:0]    w_rd_data;
    logic [mrq_pkg::IDX_W-1:0]    w_alu_a;
    logic [mrq_pkg::CNT_W-1:0]    w_alu_b;
    logic [mrq_pkg::IDX_W-1:0]    w_alu_sum;
    logic                         w_full;
    logic [mrq_pkg::CNT_W-1:0]    w_count_inc;
    logic [mrq_pkg::CNT_W-1:0]    w_qsize;

    mrq_ring_alu u_alu (
        .i_a    (w_alu_a),
        .i_b    (w_alu_b),
        .i_size (r_size),
        .o_sum  (w_alu_sum)
    );

    mrq_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .o_valid   (w_valid),
        .o_rd_data (w_rd_data)
    );

    assign w_full      = (r_count >= r_size);
    assign w_count_inc = r_count + mrq_pkg::CNT_W'(1);

    assign i_req.ready         = (r_state == S_IDLE);
    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.msg_out       = r_o_msg;
    assign o_rsp.next_location = r_o_next;
    assign o_rsp.fill_count    = r_o_fill;
    assign o_rsp.high_water    = r_o_high;

    // ring size clamped to 1..DEPTH
    always_comb begin
        w_qsize = i_cfg_data[mrq_pkg::CNT_W-1:0];
        if (w_qsize == '0) begin
            w_qsize = mrq_pkg::CNT_W'(1);
        end else if (w_qsize > mrq_pkg::CNT_W'(mrq_pkg::DEPTH)) begin
            w_qsize = mrq_pkg::CNT_W'(mrq_pkg::DEPTH);
        end
    end

    // shared adder operand select
    always_comb begin
        w_alu_a = r_head;
        w_alu_b = mrq_pkg::CNT_W'(1);
        case (r_state)
            S_EXEC: begin
                if (r_op == mrq_pkg::OP_BROWSE) begin
                    w_alu_b = r_count;
                end
            end
            S_PUT: begin
                w_alu_b = r_count;
            end
            S_SCAN1, S_SCAN2: begin
                w_alu_a = r_loc;
            end
            default: begin
                w_alu_a = r_head;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_msg_in   = r_msg_in;
        n_start    = r_start;
        n_cursor   = r_cursor;
        n_head     = r_head;
        n_count    = r_count;
        n_peak     = r_peak;
        n_ow       = r_ow;
        n_size     = r_size;
        n_tail     = r_tail;
        n_loc      = r_loc;
        n_iter     = r_iter;
        n_status   = r_status;
        n_msg_out  = r_msg_out;
        n_next     = r_next;
        n_o_valid  = r_o_valid;
        n_o_status = r_o_status;
        n_o_msg    = r_o_msg;
        n_o_next   = r_o_next;
        n_o_fill   = r_o_fill;
        n_o_high   = r_o_high;

        w_cmd          = '0;
        w_cmd.wr_addr  = r_head;
        w_cmd.rd_addr  = r_head;

        if (r_o_valid && o_rsp.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op     = i_req.op;
                    n_msg_in = i_req.msg_in;
                    n_start  = i_req.browse_start;
                    n_cursor = i_req.browse_location;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status  = mrq_pkg::ST_OK;
                n_msg_out = '0;
                n_next    = '0;
                n_state   = S_FINISH;
                case (r_op)
                    mrq_pkg::OP_PUT: begin
                        if (w_full && !r_ow) begin
                            n_status = mrq_pkg::ST_FULL;
                        end else begin
                            // drop the oldest word to make room
                            if (w_full) begin
                                n_head  = w_alu_sum;
                                n_count = r_size - mrq_pkg::CNT_W'(1);
                            end
                            n_state = S_PUT;
                        end
                    end
                    mrq_pkg::OP_GET: begin
                        if (r_count == '0) begin
                            n_status = mrq_pkg::ST_EMPTY;
                        end else begin
                            w_cmd.rd_en = 1'b1;
                            n_state     = S_GET;
                        end
                    end
                    mrq_pkg::OP_BROWSE: begin
                        n_next = r_cursor;
                        if (!r_start && (r_size == mrq_pkg::CNT_W'(1) ||
                                {1'b0, r_cursor} >= r_size)) begin
                            n_status = mrq_pkg::ST_REFUSED;
                        end else if (r_count == '0) begin
                            n_status = mrq_pkg::ST_EMPTY;
                        end else begin
                            n_tail  = w_alu_sum;
                            n_loc   = r_start ? r_head : r_cursor;
                            n_iter  = '0;
                            n_state = S_SCAN1;
                        end
                    end
                    default: begin
                        n_status = mrq_pkg::ST_REFUSED;
                    end
                endcase
            end
            S_PUT: begin
                w_cmd.wr_en    = 1'b1;
                w_cmd.wr_addr  = w_alu_sum;
                w_cmd.wr_data  = r_msg_in;
                w_cmd.wr_valid = (r_msg_in != '0);
                n_count        = w_count_inc;
                if (w_count_inc > r_peak) begin
                    n_peak = w_count_inc;
                end
                n_state = S_FINISH;
            end
            S_GET: begin
                n_msg_out      = w_valid[r_head] ? w_rd_data : '0;
                w_cmd.wr_en    = 1'b1;
                w_cmd.wr_addr  = r_head;
                w_cmd.wr_data  = '0;
                w_cmd.wr_valid = 1'b0;
                n_head         = w_alu_sum;
                n_count        = r_count - mrq_pkg::CNT_W'(1);
                n_state        = S_FINISH;
            end
            S_SCAN1: begin
                // stop at a valid slot, at the tail or after a full pass
                if (r_iter == r_size || w_valid[r_loc] ||
                        (r_loc == r_tail && r_size != mrq_pkg::CNT_W'(1))) begin
                    n_state = S_CHK;
                end else begin
                    n_loc  = w_alu_sum;
                    n_iter = r_iter + mrq_pkg::CNT_W'(1);
                end
            end
            S_CHK: begin
                if (r_loc == r_tail && r_size > mrq_pkg::CNT_W'(1) && !r_start) begin
                    n_status = mrq_pkg::ST_EMPTY;
                    n_state  = S_FINISH;
                end else begin
                    n_iter  = '0;
                    n_state = S_SCAN2;
                end
            end
            S_SCAN2: begin
                if (r_iter == r_size) begin
                    n_status = mrq_pkg::ST_EMPTY;
                    n_state  = S_FINISH;
                end else if (w_valid[r_loc]) begin
                    w_cmd.rd_en   = 1'b1;
                    w_cmd.rd_addr = r_loc;
                    n_next        = w_alu_sum;
                    n_state       = S_BR_RD;
                end else begin
                    n_loc  = w_alu_sum;
                    n_iter = r_iter + mrq_pkg::CNT_W'(1);
                end
            end
            S_BR_RD: begin
                n_msg_out = w_rd_data;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_msg    = r_msg_out;
                    n_o_next   = r_next;
                    n_o_fill   = r_count;
                    n_o_high   = r_peak;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_idx)
                mrq_pkg::CFG_OVERWRITE: begin
                    n_ow = i_cfg_data[0];
                end
                mrq_pkg::CFG_QSIZE: begin
                    n_size        = w_qsize;
                    n_head        = '0;
                    n_count       = '0;
                    n_peak        = '0;
                    w_cmd.clr_all = 1'b1;
                end
                default: begin
                    n_ow = r_ow;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= '0;
            r_peak    <= '0;
            r_ow      <= 1'b1;
            r_size    <= mrq_pkg::CNT_W'(mrq_pkg::DEPTH);
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_peak    <= n_peak;
            r_ow      <= n_ow;
            r_size    <= n_size;
            r_o_valid <= n_o_valid;
        end
        r_op       <= n_op;
        r_msg_in   <= n_msg_in;
        r_start    <= n_start;
        r_cursor   <= n_cursor;
        r_tail     <= n_tail;
        r_loc      <= n_loc;
        r_iter     <= n_iter;
        r_status   <= n_status;
        r_msg_out  <= n_msg_out;
        r_next     <= n_next;
        r_o_status <= n_o_status;
        r_o_msg    <= n_o_msg;
        r_o_next   <= n_o_next;
        r_o_fill   <= n_o_fill;
        r_o_high   <= n_o_high;
    end
endmodule

// ----- sv/mrq_checker.sv -----
// ============================================================================
// mrq_checker: port-level checks for the message ring queue
// Watches the request and response channels and flags bad results.
// ============================================================================
module mrq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_req_valid,
    input logic                            i_req_ready,
    input logic                            i_rsp_valid,
    input logic                            i_rsp_ready,
    input logic [mrq_pkg::STATUS_W-1:0]    i_rsp_status,
    input logic [mrq_pkg::MSG_W-1:0]       i_rsp_msg_out,
    input logic [mrq_pkg::CNT_W-1:0]       i_rsp_fill_count,
    input logic [mrq_pkg::CNT_W-1:0]       i_rsp_high_water
);
    // one request in flight: ready drops right after a word is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while another is in flight");

    a_fill_le_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_fill_count <= i_rsp_high_water))
        else $error("fill count above high-water mark");

    a_high_le_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_high_water <= mrq_pkg::CNT_W'(mrq_pkg::DEPTH)))
        else $error("high-water mark above queue depth");

    a_fail_no_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != mrq_pkg::ST_OK) |-> (i_rsp_msg_out == '0))
        else $error("failed request returned a handle");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_msg_out)))
        else $error("stalled response word changed");
endmodule

bind message_ring_queue mrq_checker u_mrq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_req_valid      (i_req.valid),
    .i_req_ready      (i_req.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_status     (o_rsp.status),
    .i_rsp_msg_out    (o_rsp.msg_out),
    .i_rsp_fill_count (o_rsp.fill_count),
    .i_rsp_high_water (o_rsp.high_water)
);

// ----- bench/message_ring_queue_tb.sv -----
// ============================================================================
// message_ring_queue_tb: self-checking bench for the message ring queue
// Drives put, get and browse words in bursts under several queue sizes and
// both full-queue policies. A scoreboard class carries its own copy of the
// ring and predicts each reply. Replies are checked in order, field by field.
// ============================================================================
module message_ring_queue_tb;

    // op code the block must refuse
    localparam logic [mrq_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int N_PHASES = 12;
    localparam int PHASE_WORDS = 120;

    typedef struct {
        logic [mrq_pkg::OP_W-1:0]  op;
        logic [mrq_pkg::MSG_W-1:0] msg;
        logic                      start;
        logic [mrq_pkg::IDX_W-1:0] loc;
    } t_mrq_word;

    typedef struct {
        int                           seq;
        logic [mrq_pkg::STATUS_W-1:0] status;
        logic [mrq_pkg::MSG_W-1:0]    msg_out;
        logic [mrq_pkg::IDX_W-1:0]    next_loc;
        logic [mrq_pkg::CNT_W-1:0]    fill;
        logic [mrq_pkg::CNT_W-1:0]    high;
    } t_mrq_reply;

    class t_queue_scoreboard;
        logic [mrq_pkg::MSG_W-1:0] slot_msg [mrq_pkg::DEPTH];
        bit                        slot_live [mrq_pkg::DEPTH];
        int                        head;
        int                        count;
        int                        peak;
        bit                        overwrite;
        int                        qsize;
        int                        browse_cursor;
        int                        n_words;
        int                        errors;
        t_mrq_reply                pending_replies[$];

        function new();
            overwrite = 1'b1;
            qsize     = mrq_pkg::DEPTH;
            errors    = 0;
            n_words   = 0;
            clear_ring();
        endfunction

        function void clear_ring();
            for (int i = 0; i < mrq_pkg::DEPTH; i++) begin
                slot_msg[i]  = '0;
                slot_live[i] = 1'b0;
            end
            head          = 0;
            count         = 0;
            peak          = 0;
            browse_cursor = 0;
        endfunction

        function int ring_len();
            if (qsize < 1) return 1;
            if (qsize > mrq_pkg::DEPTH) return mrq_pkg::DEPTH;
            return qsize;
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function void set_reg(logic [mrq_pkg::CFG_IDX_W-1:0] idx,
                              logic [mrq_pkg::CFG_W-1:0] data);
            if (idx == mrq_pkg::CFG_OVERWRITE) begin
                overwrite = data[0];
            end else if (idx == mrq_pkg::CFG_QSIZE) begin
                qsize = int'(data);
                clear_ring();
            end
        endfunction

        // advance the ring by one accepted word and queue the reply it owes
        function void note_request(t_mrq_word w);
            t_mrq_reply r;
            int sz;
            int pos;
            int tail;
            int loc;
            bit found;
            sz         = ring_len();
            r.seq      = n_words;
            r.status   = mrq_pkg::ST_OK;
            r.msg_out  = '0;
            r.next_loc = '0;
            n_words++;
            case (w.op)
                mrq_pkg::OP_PUT: begin
                    if (count >= sz && !overwrite) begin
                        r.status = mrq_pkg::ST_FULL;
                    end else begin
                        if (count >= sz) begin
                            head  = (head + 1) % sz;
                            count = sz - 1;
                        end
                        pos            = (head + count) % sz;
                        slot_msg[pos]  = w.msg;
                        slot_live[pos] = (w.msg != '0);
                        count++;
                        if (count > peak) peak = count;
                    end
                end
                mrq_pkg::OP_GET: begin
                    if (count == 0) begin
                        r.status = mrq_pkg::ST_EMPTY;
                    end else begin
                        pos            = head % sz;
                        r.msg_out      = slot_live[pos] ? slot_msg[pos] : '0;
                        slot_live[pos] = 1'b0;
                        slot_msg[pos]  = '0;
                        head           = (pos + 1) % sz;
                        count--;
                    end
                end
                mrq_pkg::OP_BROWSE: begin
                    tail       = (head + count) % sz;
                    found      = 1'b0;
                    r.next_loc = w.loc;
                    if ((sz == 1 && !w.start) || (!w.start && int'(w.loc) >= sz)) begin
                        r.status = mrq_pkg::ST_REFUSED;
                    end else begin
                        loc = w.start ? head % sz : int'(w.loc);
                        // first pass stops on a live slot or at the tail
                        if (count != 0) begin
                            for (int i = 0; i < sz; i++) begin
                                if (slot_live[loc] || (loc == tail && sz != 1)) break;
                                loc = (loc + 1) % sz;
                            end
                        end
                        if (count == 0 || (loc == tail && sz > 1 && !w.start)) begin
                            r.status = mrq_pkg::ST_EMPTY;
                        end else begin
                            for (int i = 0; i < sz; i++) begin
                                if (slot_live[loc]) begin
                                    found = 1'b1;
                                    break;
                                end
                                loc = (loc + 1) % sz;
                            end
                            if (!found) begin
                                r.status = mrq_pkg::ST_EMPTY;
                            end else begin
                                r.msg_out  = slot_msg[loc];
                                r.next_loc = mrq_pkg::IDX_W'((loc + 1) % sz);
                            end
                        end
                    end
                    browse_cursor = (r.status == mrq_pkg::ST_OK) ? int'(r.next_loc) : 0;
                end
                default: r.status = mrq_pkg::ST_REFUSED;
            endcase
            r.fill = mrq_pkg::CNT_W'(count);
            r.high = mrq_pkg::CNT_W'(peak);
            pending_replies.push_back(r);
        endfunction

        task report(string what);
            if (errors < 40) $display("MISMATCH %s", what);
            errors++;
        endtask

        task check_result(t_mrq_reply got);
            t_mrq_reply exp;
            if (pending_replies.size() == 0) begin
                report($sformatf("reply with nothing outstanding: status %0d msg %h",
                    got.status, got.msg_out));
                return;
            end
            exp = pending_replies.pop_front();
            if (got.status !== exp.status)
                report($sformatf("word %0d status got %0d exp %0d",
                    exp.seq, got.status, exp.status));
            if (got.msg_out !== exp.msg_out)
                report($sformatf("word %0d msg_out got %h exp %h",
                    exp.seq, got.msg_out, exp.msg_out));
            if (got.next_loc !== exp.next_loc)
                report($sformatf("word %0d next_location got %0d exp %0d",
                    exp.seq, got.next_loc, exp.next_loc));
            if (got.fill !== exp.fill)
                report($sformatf("word %0d fill_count got %0d exp %0d",
                    exp.seq, got.fill, exp.fill));
            if (got.high !== exp.high)
                report($sformatf("word %0d high_water got %0d exp %0d",
                    exp.seq, got.high, exp.high));
        endtask
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          cfg_we;
    logic [mrq_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [mrq_pkg::CFG_W-1:0]     cfg_data;

    mrq_req_if req_ch();
    mrq_rsp_if rsp_ch();

    t_queue_scoreboard sb = new();
    t_mrq_word         directed_q[$];
    int                put_pct;

    message_ring_queue i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: stall pattern switches between open, random and long holds
    initial begin
        int mode;
        int mode_left;
        int hold;
        mode_left = 0;
        hold      = 0;
        mode      = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= ($urandom_range(99) >= 30);
                default: begin
                    if (hold > 0) begin
                        hold--;
                        rsp_ch.ready <= 1'b0;
                    end else begin
                        if ($urandom_range(9) == 0) hold = $urandom_range(1, 12);
                        rsp_ch.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_mrq_reply got;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got.seq      = 0;
            got.status   = rsp_ch.status;
            got.msg_out  = rsp_ch.msg_out;
            got.next_loc = rsp_ch.next_location;
            got.fill     = rsp_ch.fill_count;
            got.high     = rsp_ch.high_water;
            sb.check_result(got);
        end
    end

    function automatic t_mrq_word mk_word(logic [mrq_pkg::OP_W-1:0] op,
                                          logic [mrq_pkg::MSG_W-1:0] msg,
                                          logic start,
                                          logic [mrq_pkg::IDX_W-1:0] loc);
        t_mrq_word w;
        w.op    = op;
        w.msg   = msg;
        w.start = start;
        w.loc   = loc;
        return w;
    endfunction

    function automatic t_mrq_word random_word();
        t_mrq_word w;
        int r;
        int sz;
        sz      = sb.ring_len();
        r       = $urandom_range(99);
        w.start = 1'($urandom_range(1));
        w.loc   = mrq_pkg::IDX_W'($urandom_range(63));
        case ($urandom_range(19))
            0: w.msg = '0;
            1: w.msg = '1;
            default: w.msg = $urandom;
        endcase
        if (r == 99) begin
            w.op = OP_UNUSED;
        end else if (r < put_pct) begin
            w.op = mrq_pkg::OP_PUT;
        end else if (r < put_pct + (99 - put_pct) / 2) begin
            w.op = mrq_pkg::OP_GET;
        end else begin
            w.op    = mrq_pkg::OP_BROWSE;
            w.start = ($urandom_range(3) == 0);
            if (!w.start) begin
                r = $urandom_range(99);
                // mostly continue the walk from the last good browse
                if (r < 60) w.loc = mrq_pkg::IDX_W'(sb.browse_cursor);
                else if (r < 85) w.loc = mrq_pkg::IDX_W'($urandom_range(sz - 1));
            end
        end
        return w;
    endfunction

    // entered at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(t_mrq_word w);
        req_ch.valid           <= 1'b1;
        req_ch.op              <= w.op;
        req_ch.msg_in          <= w.msg;
        req_ch.browse_start    <= w.start;
        req_ch.browse_location <= w.loc;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(w);
        @(negedge i_clk);
    endtask

    task automatic drive_phase(int n_random);
        int left;
        int burst;
        int gap;
        t_mrq_word w;
        left = directed_q.size() + n_random;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0) begin
                if (directed_q.size() != 0) w = directed_q.pop_front();
                else w = random_word();
                send_word(w);
                burst--;
                left--;
            end
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0 || left == 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic set_regs(logic ow, int sz);
        cfg_we   <= 1'b1;
        cfg_idx  <= mrq_pkg::CFG_OVERWRITE;
        cfg_data <= mrq_pkg::CFG_W'(ow);
        sb.set_reg(mrq_pkg::CFG_OVERWRITE, mrq_pkg::CFG_W'(ow));
        @(negedge i_clk);
        cfg_idx  <= mrq_pkg::CFG_QSIZE;
        cfg_data <= mrq_pkg::CFG_W'(sz);
        sb.set_reg(mrq_pkg::CFG_QSIZE, mrq_pkg::CFG_W'(sz));
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        int phase_ow [N_PHASES];
        int phase_sz [N_PHASES];
        int drain;
        phase_ow = '{1, 0, 1, 0, 1, 0, 1, 0, 1, 0, 1, 0};
        phase_sz = '{64, 64, 1, 1, 2, 3, 5, 8, 0, 0, 16, 4};
        phase_sz[8] = $urandom_range(1, 64);
        phase_sz[9] = $urandom_range(1, 64);

        i_rst_n                <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_idx                <= mrq_pkg::CFG_OVERWRITE;
        cfg_data               <= '0;
        req_ch.valid           <= 1'b0;
        req_ch.op              <= mrq_pkg::OP_PUT;
        req_ch.msg_in          <= '0;
        req_ch.browse_start    <= 1'b0;
        req_ch.browse_location <= '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        put_pct = 45;

        // reset settings: empty cases, zero handle, browse walk to the tail
        directed_q.push_back(mk_word(mrq_pkg::OP_GET, '0, 1'b0, '0));
        directed_q.push_back(mk_word(mrq_pkg::OP_BROWSE, '0, 1'b1, '0));
        directed_q.push_back(mk_word(mrq_pkg::OP_PUT, '1, 1'b0, '0));
        directed_q.push_back(mk_word(mrq_pkg::OP_PUT, '0, 1'b0, '0));
        directed_q.push_back(mk_word(mrq_pkg::OP_PUT, 32'h0000_0001, 1'b0, '0));
        directed_q.push_back(mk_word(mrq_pkg::OP_PUT, 32'h8000_0000, 1'b0, '0));
        directed_q.push_back(mk_word(mrq_pkg::OP_BROWSE, '0, 1'b1, 6'd63));
        directed_q.push_back(mk_word(mrq_pkg::OP_BROWSE, '0, 1'b0, 6'd1));
        directed_q.push_back(mk_word(mrq_pkg::OP_BROWSE, '0, 1'b0, 6'd3));
        directed_q.push_back(mk_word(mrq_pkg::OP_BROWSE, '0, 1'b0, 6'd4));
        directed_q.push_back(mk_word(OP_UNUSED, '1, 1'b1, '1));
        directed_q.push_back(mk_word(mrq_pkg::OP_GET, '0, 1'b0, '0));
        directed_q.push_back(mk_word(mrq_pkg::OP_GET, '0, 1'b0, '0));
        drive_phase(0);
        wait_drained();

        // single slot: overwrite, browse without start refused
        set_regs(1'b1, 1);
        directed_q.push_back(mk_word(mrq_pkg::OP_PUT, 32'h1234_5678, 1'b0, '0));
        directed_q.push_back(mk_word(mrq_pkg::OP_PUT, 32'h7EDC_BA98, 1'b0, '0));
        directed_q.push_back(mk_word(mrq_pkg::OP_BROWSE, '0, 1'b0, '0));
        directed_q.push_back(mk_word(mrq_pkg::OP_BROWSE, '0, 1'b1, '0));
        directed_q.push_back(mk_word(mrq_pkg::OP_GET, '0, 1'b0, '0));
        drive_phase(0);
        wait_drained();

        // reject mode: only zero handles, fill the ring, cursor past the ring
        set_regs(1'b0, 4);
        directed_q.push_back(mk_word(mrq_pkg::OP_PUT, '0, 1'b0, '0));
        directed_q.push_back(mk_word(mrq_pkg::OP_PUT, '0, 1'b0, '0));
        directed_q.push_back(mk_word(mrq_pkg::OP_BROWSE, '0, 1'b1, '0));
        directed_q.push_back(mk_word(mrq_pkg::OP_PUT, 32'h0000_0007, 1'b0, '0));
        directed_q.push_back(mk_word(mrq_pkg::OP_PUT, 32'h0000_0009, 1'b0, '0));
        directed_q.push_back(mk_word(mrq_pkg::OP_BROWSE, '0, 1'b0, 6'd5));
        drive_phase(0);

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            set_regs(phase_ow[p][0], phase_sz[p]);
            put_pct = $urandom_range(35, 65);
            drive_phase(PHASE_WORDS);
        end

        wait_drained();
        // catch any reply that should not come
        drain = 0;
        while (drain < 200) begin
            @(negedge i_clk);
            drain++;
        end
        if (sb.pending() != 0) sb.report($sformatf("%0d replies never came", sb.pending()));
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
